// ===== src/hfd_pkg.sv =====
// Shared types and constants for the pulse frame decoder.
// No dependencies; imported by every module of the block.
package hfd_pkg;

   localparam int WIDTH_W     = 15;
   localparam int COUNT_W     = 6;
   localparam int FRAME_W     = 40;
   localparam int READING_W   = 16;
   localparam int CSR_ADDR_W  = 2;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 32;
   localparam int RSP_USER_W  = 2;

   localparam logic [COUNT_W-1:0] FRAME_SYMBOLS    = 6'd43;
   localparam logic [COUNT_W-1:0] FIRST_BIT_SYMBOL = 6'd2;
   localparam logic [COUNT_W-1:0] LAST_BIT_SYMBOL  = 6'd41;
   localparam logic [COUNT_W-1:0] COUNT_MAX        = 6'd63;

   localparam logic [WIDTH_W-1:0] SEP_MIN_RESET = 15'd44;
   localparam logic [WIDTH_W-1:0] SEP_MAX_RESET = 15'd56;
   localparam logic [WIDTH_W-1:0] ONE_MIN_RESET = 15'd65;
   localparam logic [WIDTH_W-1:0] ONE_MAX_RESET = 15'd75;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SEP_MIN = 2'd0,
      CSR_SEP_MAX = 2'd1,
      CSR_ONE_MIN = 2'd2,
      CSR_ONE_MAX = 2'd3
   } csr_index_type;

   typedef enum logic [RSP_USER_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_CHECKSUM = 2'd1,
      STATUS_LENGTH   = 2'd2
   } status_type;

   typedef struct packed {
      logic [WIDTH_W-1:0] sep_min;
      logic [WIDTH_W-1:0] sep_max;
      logic [WIDTH_W-1:0] one_min;
      logic [WIDTH_W-1:0] one_max;
   } window_type;

   typedef struct packed {
      logic               first_level;
      logic [WIDTH_W-1:0] first_width;
      logic               second_level;
      logic [WIDTH_W-1:0] second_width;
      logic               frame_end;
   } symbol_type;

   typedef struct packed {
      status_type           status;
      logic [READING_W-1:0] humidity_tenths;
      logic [READING_W-1:0] temperature_tenths;
   } result_type;

endpackage

// ===== src/humidity_temp_pulse_frame_decoder_top.sv =====
// Top level of the humidity/temperature pulse frame decoder.
// Depends on hfd_pkg, hfd_csr, hfd_frame and hfd_out_reg.
//
// Use:
//  - req channel: one captured pulse symbol per transfer; req_tlast marks
//    the last symbol of a frame. Symbols 2 to 41 of a frame each add one
//    bit, MSB first, to a 40-bit frame.
//  - rsp channel: exactly one transfer per frame, on the req_tlast symbol.
//    rsp_tuser carries the status (ok, checksum error, wrong length),
//    rsp_tdata humidity and signed temperature in tenths. A wrong-length
//    frame repeats the last stored readings.
//  - csr port: window registers, which the user writes only while the block is idle (not enforced).
// Timing:
//  - one symbol per cycle sustained, except while a frame-end symbol waits;
//    a symbol sits in the input register, then the compare, shift and
//    decode feed the result register, from which the result shows on rsp.
//  - when rsp stalls, the result holds; non-final symbols keep flowing and
//    only a frame-end symbol waits in the input register for room.
// Reset: windows return to 44/56/65/75 ticks, symbol count, frame bits
// and stored readings clear; no clearing pass, ready in the next cycle.
module humidity_temp_pulse_frame_decoder_top (
   input  logic                            clock,
   input  logic                            reset,
   // symbol input
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [0] first_level, [15:1] first_width, [16] second_level,
   // [31:17] second_width
   input  logic [hfd_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tlast,
   // decoded frame
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [15:0] humidity_tenths, [31:16] temperature_tenths
   output logic [hfd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [1:0] status
   output logic [hfd_pkg::RSP_USER_W-1:0]  rsp_tuser,
   // window registers
   input  logic                            csr_we,
   input  logic [hfd_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [hfd_pkg::WIDTH_W-1:0]     csr_wdata
);
   import hfd_pkg::*;

   window_type windows;
   symbol_type sym;
   result_type res;
   result_type rsp;
   logic       res_valid;
   logic       res_ready;

   // unpack the transfer, lowest field in the lowest bits
   assign sym.first_level  = req_tdata[0];
   assign sym.first_width  = req_tdata[15:1];
   assign sym.second_level = req_tdata[16];
   assign sym.second_width = req_tdata[31:17];
   assign sym.frame_end    = req_tlast;

   hfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .windows   (windows)
   );

   hfd_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .windows   (windows),
      .sym_valid (req_tvalid),
      .sym_ready (req_tready),
      .sym       (sym),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   hfd_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {rsp.temperature_tenths, rsp.humidity_tenths};
   assign rsp_tuser = rsp.status;

endmodule

// ===== src/hfd_csr.sv =====
// Window registers for the pulse frame decoder, written over the csr port.
// Depends on hfd_pkg.
module hfd_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [hfd_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [hfd_pkg::WIDTH_W-1:0]    csr_wdata,
   output hfd_pkg::window_type            windows
);
   import hfd_pkg::*;

   window_type win_ff, win_in;

   always_comb begin
      win_in = win_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_SEP_MIN: win_in.sep_min = csr_wdata;
            CSR_SEP_MAX: win_in.sep_max = csr_wdata;
            CSR_ONE_MIN: win_in.one_min = csr_wdata;
            CSR_ONE_MAX: win_in.one_max = csr_wdata;
            default:     win_in = win_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff.sep_min <= SEP_MIN_RESET;
         win_ff.sep_max <= SEP_MAX_RESET;
         win_ff.one_min <= ONE_MIN_RESET;
         win_ff.one_max <= ONE_MAX_RESET;
      end else begin
         win_ff <= win_in;
      end
   end

   assign windows = win_ff;

endmodule

// ===== src/hfd_frame.sv =====
// Symbol input register, bit collection, frame state and reading decode.
// Depends on hfd_pkg.
module hfd_frame (
   input  logic                clock,
   input  logic                reset,
   input  hfd_pkg::window_type windows,
   input  logic                sym_valid,
   output logic                sym_ready,
   input  hfd_pkg::symbol_type sym,
   output logic                res_valid,
   input  logic                res_ready,
   output hfd_pkg::result_type res
);
   import hfd_pkg::*;

   logic                 hold_valid_ff, hold_valid_in;
   symbol_type           hold_ff;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [FRAME_W-1:0]   bits_ff, bits_in;
   logic [READING_W-1:0] hum_ff, hum_in;
   logic [READING_W-1:0] temp_ff, temp_in;

   logic                 advance;
   logic                 in_bit_span;
   logic                 sep_ok;
   logic                 one_ok;
   logic [FRAME_W-1:0]   bits_next;
   logic [COUNT_W-1:0]   total;
   logic [7:0]           b0, b1, b2, b3, b4;
   logic [7:0]           sum;
   logic [READING_W-1:0] mag;
   logic [READING_W-1:0] temp_dec;
   logic                 full_frame;

   // an end symbol needs room in the result register, others always move on
   assign advance   = hold_valid_ff && (!hold_ff.frame_end || res_ready);
   assign sym_ready = !hold_valid_ff || advance;

   assign in_bit_span = (count_ff >= FIRST_BIT_SYMBOL) && (count_ff <= LAST_BIT_SYMBOL);
   assign sep_ok = !hold_ff.first_level
                   && (hold_ff.first_width >= windows.sep_min)
                   && (hold_ff.first_width <= windows.sep_max);
   assign one_ok = hold_ff.second_level
                   && (hold_ff.second_width >= windows.one_min)
                   && (hold_ff.second_width <= windows.one_max);
   assign bits_next = in_bit_span ? {bits_ff[FRAME_W-2:0], sep_ok && one_ok} : bits_ff;
   assign total = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + 6'd1;
   assign full_frame = (total == FRAME_SYMBOLS);

   assign b0 = bits_next[39:32];
   assign b1 = bits_next[31:24];
   assign b2 = bits_next[23:16];
   assign b3 = bits_next[15:8];
   assign b4 = bits_next[7:0];
   assign sum = b0 + b1 + b2 + b3;
   assign mag = {1'b0, b2[6:0], b3};
   // negative zero folds to zero through the two's complement
   assign temp_dec = b2[7] ? (16'd0 - mag) : mag;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      count_in      = count_ff;
      bits_in       = bits_ff;
      hum_in        = hum_ff;
      temp_in       = temp_ff;
      if (advance) begin
         hold_valid_in = 1'b0;
         if (hold_ff.frame_end) begin
            count_in = '0;
            bits_in  = '0;
            if (full_frame) begin
               hum_in  = {b0, b1};
               temp_in = temp_dec;
            end
         end else begin
            count_in = total;
            bits_in  = bits_next;
         end
      end
      if (sym_valid && sym_ready) begin
         hold_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         count_ff      <= '0;
         bits_ff       <= '0;
         hum_ff        <= '0;
         temp_ff       <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         count_ff      <= count_in;
         bits_ff       <= bits_in;
         hum_ff        <= hum_in;
         temp_ff       <= temp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sym_valid && sym_ready) begin
         hold_ff <= sym;
      end
   end

   always_comb begin
      res_valid = hold_valid_ff && hold_ff.frame_end;
      if (!full_frame) begin
         res.status             = STATUS_LENGTH;
         res.humidity_tenths    = hum_ff;
         res.temperature_tenths = temp_ff;
      end else begin
         res.status             = (b4 == sum) ? STATUS_OK : STATUS_CHECKSUM;
         res.humidity_tenths    = {b0, b1};
         res.temperature_tenths = temp_dec;
      end
   end

   a_frame_clears: assert property (@(posedge clock) disable iff (reset)
      advance && hold_ff.frame_end |=> (count_ff == '0) && (bits_ff == '0))
      else $error("frame state not cleared after frame end");

   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      advance && !hold_ff.frame_end && (count_ff != COUNT_MAX)
      |=> count_ff == 6'($past(count_ff) + 6'd1))
      else $error("symbol count did not step");

   a_decode_length: assert property (@(posedge clock) disable iff (reset)
      res_valid && (res.status != STATUS_LENGTH) |-> count_ff == (FRAME_SYMBOLS - 6'd1))
      else $error("decoded reading from a frame of wrong length");

   a_readings_kept: assert property (@(posedge clock) disable iff (reset)
      advance && !(hold_ff.frame_end && full_frame) |=> $stable(hum_ff) && $stable(temp_ff))
      else $error("stored readings changed without a full frame");

endmodule

// ===== src/hfd_out_reg.sv =====
// Result register for the pulse frame decoder, driving the rsp channel.
// Depends on hfd_pkg.
module hfd_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                res_valid,
   output logic                res_ready,
   input  hfd_pkg::result_type res,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output hfd_pkg::result_type rsp
);
   import hfd_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign res_ready = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (res_ready) begin
         valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         data_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp        = data_ff;

endmodule
